[rtl/scs_pkg.sv]
// Shared types and constants for the sensor command sequencer.
package scs_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int MAX_BEATS       = 10;
	localparam int CMD_COUNT       = 10;

	localparam logic [1:0] KIND_POWER   = 2'd0;
	localparam logic [1:0] KIND_COMMAND = 2'd1;
	localparam logic [1:0] KIND_POLL    = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	localparam logic [3:0] CMD_SETTIME       = 4'd0;
	localparam logic [3:0] CMD_GETTIME       = 4'd1;
	localparam logic [3:0] CMD_STATUS_COMMON = 4'd2;
	localparam logic [3:0] CMD_STATUS_EXT    = 4'd3;
	localparam logic [3:0] CMD_STATUS_BOTH   = 4'd4;
	localparam logic [3:0] CMD_GETINTERVALS  = 4'd5;
	localparam logic [3:0] CMD_SETINT_FGDOS  = 4'd6;
	localparam logic [3:0] CMD_SETINT_RADFET = 4'd7;
	localparam logic [3:0] CMD_SETINT_SRAM   = 4'd8;
	localparam logic [3:0] CMD_SHUTDOWN      = 4'd9;
	localparam logic [3:0] CMD_NONE          = 4'd15;

	localparam logic [3:0] EV_POWER_ON     = 4'd0;
	localparam logic [3:0] EV_POWER_OFF    = 4'd1;
	localparam logic [3:0] EV_ERROR        = 4'd2;
	localparam logic [3:0] EV_TIME         = 4'd3;
	localparam logic [3:0] EV_STATUS       = 4'd4;
	localparam logic [3:0] EV_INTERVALS    = 4'd5;
	localparam logic [3:0] EV_INTERVAL_SET = 4'd6;
	localparam logic [3:0] EV_SHUTDOWN     = 4'd7;
	localparam logic [3:0] EV_DATA         = 4'd8;
	localparam logic [3:0] EV_NONE         = 4'd0;

	localparam logic [6:0] ADDR_POWER = 7'h47;
	localparam logic [6:0] ADDR_CTRL  = 7'h0B;

	localparam logic [7:0] PWR_LEAD     = 8'h00;
	localparam logic [7:0] PWR_ON_BYTE  = 8'h1F;
	localparam logic [7:0] PWR_OFF_BYTE = 8'h17;
	localparam logic [7:0] OP_SETTIME   = 8'h0D;
	localparam logic [7:0] OP_GETTIME   = 8'h0E;
	localparam logic [7:0] OP_STATUS    = 8'h0A;
	localparam logic [7:0] OP_GETINT    = 8'h0C;
	localparam logic [7:0] OP_SETINT    = 8'h0B;
	localparam logic [7:0] OP_SHUTDOWN  = 8'h0F;
	localparam logic [7:0] ERR_MARK     = 8'hFF;
	localparam logic [5:0] ERR_MIN_SIZE = 6'd3;

	localparam logic [5:0] RLEN_POWER   = 6'd0;
	localparam logic [5:0] RLEN_TIME    = 6'd10;
	localparam logic [5:0] RLEN_ST_COM  = 6'd15;
	localparam logic [5:0] RLEN_ST_EXT  = 6'd33;
	localparam logic [5:0] RLEN_ST_BOTH = 6'd45;
	localparam logic [5:0] RLEN_GETINT  = 6'd14;
	localparam logic [5:0] RLEN_SETINT  = 6'd7;
	localparam logic [5:0] RLEN_SHUT    = 6'd2;

	typedef struct packed {
		logic [3:0] code;
		logic [7:0] data;
	} ev_t;

	// One queued job: a whole frame or one or two events.
	typedef struct packed {
		logic                     is_event;
		logic [6:0]               addr;
		logic [5:0]               rlen;
		logic [3:0]               count;
		logic [MAX_BEATS-1:0][7:0] bytes;
		logic [1:0][3:0]          ev;
	} job_t;

	typedef struct packed {
		logic       result_kind;
		logic [6:0] bus_address;
		logic [7:0] data_byte;
		logic [5:0] reply_length;
		logic [3:0] event_code;
		logic       last;
	} beat_t;

endpackage

[rtl/scs_in_if.sv]
// Input channel interface: one request beat.
interface scs_in_if;
	import scs_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        power_request;
	logic [3:0]  command;
	logic [31:0] interval_value;
	logic [63:0] current_time;
	logic [5:0]  reply_size;
	logic [7:0]  reply_byte0;
	logic [7:0]  reply_byte1;

	modport source (
		output valid, kind, power_request, command, interval_value, current_time,
		       reply_size, reply_byte0, reply_byte1,
		input  ready
	);
	modport sink (
		input  valid, kind, power_request, command, interval_value, current_time,
		       reply_size, reply_byte0, reply_byte1,
		output ready
	);
endinterface

[rtl/scs_out_if.sv]
// Result channel interface: one frame byte or event beat.
interface scs_out_if;
	import scs_pkg::*;

	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [6:0] bus_address;
	logic [7:0] data_byte;
	logic [5:0] reply_length;
	logic [3:0] event_code;
	logic       last;

	modport source (
		output valid, result_kind, bus_address, data_byte, reply_length, event_code, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, bus_address, data_byte, reply_length, event_code, last,
		output ready
	);
endinterface

[rtl/scs_queue.sv]
// Small job queue between the front and back parts.
module scs_queue #(
	parameter int DEPTH = scs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scs_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output scs_pkg::job_t head,
	output logic          head_valid
);
	import scs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop && head_valid) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && head_valid);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("job pushed into full queue");

endmodule

[rtl/scs_front.sv]
// Front part: accepts request beats, keeps sequencer state, builds jobs.
module scs_front (
	input  logic          clk,
	input  logic          arst_n,
	scs_in_if.sink        item,
	input  logic          q_full,
	output logic          push,
	output scs_pkg::job_t push_job
);
	import scs_pkg::*;

	logic                 power_state_q;
	logic                 power_wanted_q;
	logic                 transfer_busy_q;
	logic                 power_transfer_q;
	logic                 power_direction_q;
	logic [CMD_COUNT-1:0] pending_q;
	logic [3:0]           active_q;
	logic [31:0]          interval_q;

	logic                 accept;
	logic [3:0]           sel_cmd;
	logic [8:0][7:0]      cb;
	logic [3:0]           cn;
	logic [5:0]           crl;
	logic [7:0]           csum;
	logic [MAX_BEATS-1:0][7:0] frame;
	logic                 err;
	logic [7:0]           b0p;
	logic [3:0]           a_eff;
	ev_t                  evm;
	job_t                 job;
	logic                 has_job;

	function automatic ev_t ev_for(logic [3:0] a, logic [7:0] bz, logic [7:0] b1);
		ev_t e;
		if (a == CMD_SETTIME || a == CMD_GETTIME) begin
			e = '{code: EV_TIME, data: bz};
		end else if (a >= CMD_STATUS_COMMON && a <= CMD_STATUS_BOTH) begin
			if (b1 != {4'd0, a - 4'd1}) e = '{code: EV_ERROR, data: b1};
			else e = '{code: EV_STATUS, data: bz};
		end else if (a == CMD_GETINTERVALS) begin
			e = '{code: EV_INTERVALS, data: b1};
		end else if (a >= CMD_SETINT_FGDOS && a <= CMD_SETINT_SRAM) begin
			e = '{code: EV_INTERVAL_SET, data: b1};
		end else if (a == CMD_SHUTDOWN) begin
			e = '{code: EV_SHUTDOWN, data: 8'd0};
		end else begin
			e = '{code: EV_DATA, data: bz};
		end
		return e;
	endfunction

	assign item.ready = !q_full;
	assign accept     = item.valid && !q_full;

	// lowest pending command wins
	always_comb begin
		sel_cmd = CMD_SHUTDOWN;
		for (int i = CMD_COUNT - 1; i >= 0; i--) begin
			if (pending_q[i]) sel_cmd = 4'(i);
		end
	end

	always_comb begin
		cb  = '0;
		cn  = 4'd1;
		crl = RLEN_SHUT;
		unique case (sel_cmd)
			CMD_SETTIME: begin
				cb[0] = OP_SETTIME;
				for (int i = 0; i < 8; i++) cb[1+i] = item.current_time[8*i +: 8];
				cn  = 4'd9;
				crl = RLEN_TIME;
			end
			CMD_GETTIME: begin
				cb[0] = OP_GETTIME;
				crl   = RLEN_TIME;
			end
			CMD_STATUS_COMMON, CMD_STATUS_EXT, CMD_STATUS_BOTH: begin
				cb[0] = OP_STATUS;
				cb[1] = {4'd0, sel_cmd - 4'd1};
				cn    = 4'd2;
				crl   = (sel_cmd == CMD_STATUS_COMMON) ? RLEN_ST_COM :
				        (sel_cmd == CMD_STATUS_EXT) ? RLEN_ST_EXT : RLEN_ST_BOTH;
			end
			CMD_GETINTERVALS: begin
				cb[0] = OP_GETINT;
				crl   = RLEN_GETINT;
			end
			CMD_SETINT_FGDOS, CMD_SETINT_RADFET, CMD_SETINT_SRAM: begin
				cb[0] = OP_SETINT;
				cb[1] = {4'd0, sel_cmd - 4'd5};
				for (int i = 0; i < 4; i++) cb[2+i] = interval_q[8*i +: 8];
				cn    = 4'd6;
				crl   = RLEN_SETINT;
			end
			default: begin
				cb[0] = OP_SHUTDOWN;
			end
		endcase
	end

	always_comb begin
		csum = '0;
		for (int i = 0; i < 9; i++) csum ^= cb[i];
		for (int i = 0; i < MAX_BEATS; i++) begin
			if (4'(i) < cn) frame[i] = (i < 9) ? cb[i] : 8'd0;
			else if (4'(i) == cn) frame[i] = csum;
			else frame[i] = 8'd0;
		end
	end

	assign err   = (item.reply_size >= ERR_MIN_SIZE) && (item.reply_byte0 == ERR_MARK);
	assign b0p   = (item.reply_size != '0) ? item.reply_byte0 : 8'd0;
	assign a_eff = err ? CMD_NONE : active_q;
	assign evm   = ev_for(a_eff, b0p, item.reply_byte1);

	always_comb begin
		job     = '0;
		has_job = 1'b0;
		unique case (item.kind)
			KIND_POLL: begin
				if (!transfer_busy_q) begin
					if (power_state_q != power_wanted_q) begin
						has_job      = 1'b1;
						job.addr     = ADDR_POWER;
						job.rlen     = RLEN_POWER;
						job.count    = 4'd2;
						job.bytes[0] = PWR_LEAD;
						job.bytes[1] = power_wanted_q ? PWR_ON_BYTE : PWR_OFF_BYTE;
					end else if (|pending_q) begin
						has_job   = 1'b1;
						job.addr  = ADDR_CTRL;
						job.rlen  = crl;
						job.count = cn + 4'd1;
						job.bytes = frame;
					end
				end
			end
			KIND_DONE: begin
				if (transfer_busy_q) begin
					has_job      = 1'b1;
					job.is_event = 1'b1;
					if (power_transfer_q) begin
						job.count    = 4'd1;
						job.bytes[0] = PWR_LEAD;
						job.ev[0]    = power_direction_q ? EV_POWER_ON : EV_POWER_OFF;
					end else if (err) begin
						job.count    = 4'd2;
						job.bytes[0] = item.reply_byte1;
						job.ev[0]    = EV_ERROR;
						job.bytes[1] = evm.data;
						job.ev[1]    = evm.code;
					end else begin
						job.count    = 4'd1;
						job.bytes[0] = evm.data;
						job.ev[0]    = evm.code;
					end
				end
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	assign push     = accept && has_job;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_state_q     <= 1'b0;
			power_wanted_q    <= 1'b0;
			transfer_busy_q   <= 1'b0;
			power_transfer_q  <= 1'b0;
			power_direction_q <= 1'b0;
			pending_q         <= '0;
			active_q          <= CMD_NONE;
			interval_q        <= '0;
		end else if (accept) begin
			unique case (item.kind)
				KIND_POWER: begin
					power_wanted_q <= item.power_request;
				end
				KIND_COMMAND: begin
					if (item.command <= CMD_SHUTDOWN) begin
						pending_q <= pending_q | (CMD_COUNT'(1) << item.command);
						if (item.command >= CMD_SETINT_FGDOS && item.command <= CMD_SETINT_SRAM) begin
							interval_q <= item.interval_value;
						end
					end
				end
				KIND_POLL: begin
					if (!transfer_busy_q) begin
						if (power_state_q != power_wanted_q) begin
							transfer_busy_q   <= 1'b1;
							power_transfer_q  <= 1'b1;
							power_direction_q <= power_wanted_q;
						end else if (|pending_q) begin
							pending_q        <= pending_q & ~(CMD_COUNT'(1) << sel_cmd);
							active_q         <= sel_cmd;
							transfer_busy_q  <= 1'b1;
							power_transfer_q <= 1'b0;
						end
					end
				end
				default: begin
					if (transfer_busy_q) begin
						transfer_busy_q <= 1'b0;
						if (power_transfer_q) begin
							power_transfer_q <= 1'b0;
							power_state_q    <= power_direction_q;
						end else if (err) begin
							active_q <= CMD_NONE;
						end
					end
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) power_transfer_q |-> transfer_busy_q)
		else $error("power transfer flagged with no transfer in flight");

endmodule

[rtl/scs_back.sv]
// Back part: walks the head job beat by beat into the output register.
module scs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  scs_pkg::job_t head,
	input  logic          head_valid,
	output logic          pop,
	scs_out_if.source     result
);
	import scs_pkg::*;

	logic [3:0] idx_q;
	logic       out_valid_q;
	beat_t      beat_q;
	beat_t      beat;
	logic       load;

	always_comb begin
		beat.result_kind  = head.is_event;
		beat.bus_address  = head.addr;
		beat.data_byte    = head.bytes[idx_q];
		beat.reply_length = head.rlen;
		beat.event_code   = head.is_event ? head.ev[idx_q[0]] : EV_NONE;
		beat.last         = (idx_q == head.count - 4'd1);
	end

	assign load = head_valid && (!out_valid_q || result.ready);
	assign pop  = load && beat.last;

	always_ff @(posedge clk) begin
		if (load) beat_q <= beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= beat.last ? 4'd0 : idx_q + 4'd1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_kind  = beat_q.result_kind;
	assign result.bus_address  = beat_q.bus_address;
	assign result.data_byte    = beat_q.data_byte;
	assign result.reply_length = beat_q.reply_length;
	assign result.event_code   = beat_q.event_code;
	assign result.last         = beat_q.last;

	assert property (@(posedge clk) disable iff (!arst_n) (idx_q != '0) |-> head_valid)
		else $error("job left the queue before its last beat");

endmodule

[rtl/sensor_command_sequencer_unit.sv]
// Top level of the sensor command sequencer.
//
// item:   request beats (power request, command request, poll, transfer done),
//         valid/ready, taken when both are high.
// result: frame bytes and event reports, valid/ready, last marks the final
//         beat caused by one request.
// A request is taken whenever the job queue has room, so requests may
// arrive every cycle. One request gives 0 to 10 result beats;
// frames are 2 to 10 bytes, completions give 1 or 2 events.
// The first beat of a request passes through the job queue and then the
// output register before it shows on result; the back part then drains
// one beat per cycle while result.ready is high.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and item.ready drops once QUEUE_DEPTH jobs wait.
// Reset clears the power, transfer and pending state, the queue and the
// output valid flag; no command is active after reset.
module sensor_command_sequencer_unit #(
	parameter int QUEUE_DEPTH = scs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	scs_in_if.sink    item,
	scs_out_if.source result
);
	import scs_pkg::*;

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic head_valid;

	scs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	scs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	scs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);

endmodule
